// ===== rtl/eesd_pkg.sv =====
package eesd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_END_ARG = 2'd1;
    localparam logic [1:0] OP_END_ALL = 2'd2;

    localparam logic [0:0] REG_INTERPRET_ESCAPES = 1'd0;
    localparam logic [0:0] REG_SUPPRESS_NEWLINE  = 1'd1;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_BACKSLASH = 2'd1;
    localparam logic [1:0] MODE_OCTAL     = 2'd2;
    localparam logic [1:0] MODE_HEX       = 2'd3;

    localparam logic [7:0] CHAR_ESC       = 8'd27;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_BACKSLASH = 8'd92;

    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } qentry_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } lookup_t;

    function automatic lookup_t named_escape(input logic [7:0] b);
        lookup_t r;
        r.hit   = 1'b1;
        r.value = 8'd0;
        case (b)
            8'h61: r.value = 8'd7;
            8'h62: r.value = 8'd8;
            8'h65: r.value = CHAR_ESC;
            8'h66: r.value = 8'd12;
            8'h6e: r.value = CHAR_NEWLINE;
            8'h72: r.value = 8'd13;
            8'h74: r.value = 8'd9;
            8'h76: r.value = 8'd11;
            8'h5c: r.value = CHAR_BACKSLASH;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic lookup_t hex_value(input logic [7:0] b);
        lookup_t r;
        r.hit   = 1'b1;
        r.value = 8'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r.value = b - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66)
            r.value = b - 8'h57;
        else if (b >= 8'h41 && b <= 8'h46)
            r.value = b - 8'h37;
        else
            r.hit = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/eesd_front.sv =====
module eesd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,   // opcode
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic              cfg_data,
    input  logic              queue_ready,
    output logic              push_valid,
    output eesd_pkg::qentry_t push_entry
);
    import eesd_pkg::*;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } result_t;

    function automatic result_t add_byte(input result_t r, input logic [7:0] x);
        result_t o;
        o = r;
        if (r.cnt == 2'd0)
            o.b0 = x;
        else
            o.b1 = x;
        o.cnt = r.cnt + 2'd1;
        return o;
    endfunction

    logic       interp_reg;
    logic       suppress_reg;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] count_reg, count_next;
    logic [8:0] value_reg, value_next;
    logic       first_reg, first_next;
    logic       open_reg, open_next;
    logic       stopped_reg, stopped_next;

    result_t res;
    lookup_t nm;
    lookup_t hx;
    logic    is_oct;
    logic    accept;
    logic [8:0] oct_val;
    logic [8:0] hex_val;

    assign s_tready  = queue_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign nm      = named_escape(s_tdata);
    assign hx      = hex_value(s_tdata);
    assign is_oct  = (s_tdata[7:3] == 5'b00110);
    assign oct_val = {value_reg[5:0], s_tdata[2:0]};
    assign hex_val = {value_reg[4:0], hx.value[3:0]};

    always_comb
    begin
        res          = '0;
        mode_next    = mode_reg;
        count_next   = count_reg;
        value_next   = value_reg;
        first_next   = first_reg;
        open_next    = open_reg;
        stopped_next = stopped_reg;
        case (s_tuser)
            OP_BYTE:
            begin
                if (!stopped_reg)
                begin
                    if (!open_reg)
                    begin
                        if (!first_reg)
                            res = add_byte(res, CHAR_SPACE);
                        first_next = 1'b0;
                        open_next  = 1'b1;
                    end
                    if (!interp_reg)
                        res = add_byte(res, s_tdata);
                    else
                    begin
                        unique case (mode_reg)
                            MODE_NORMAL:
                            begin
                                if (s_tdata == CHAR_BACKSLASH)
                                    mode_next = MODE_BACKSLASH;
                                else
                                    res = add_byte(res, s_tdata);
                            end
                            MODE_BACKSLASH:
                            begin
                                mode_next = MODE_NORMAL;
                                if (nm.hit)
                                    res = add_byte(res, nm.value);
                                else if (s_tdata == 8'h63)
                                    stopped_next = 1'b1;
                                else if (s_tdata == 8'h78)
                                begin
                                    mode_next  = MODE_HEX;
                                    count_next = 2'd0;
                                    value_next = 9'd0;
                                end
                                else if (is_oct)
                                begin
                                    mode_next  = MODE_OCTAL;
                                    count_next = 2'd1;
                                    value_next = {6'd0, s_tdata[2:0]};
                                end
                                else
                                begin
                                    res = add_byte(res, CHAR_BACKSLASH);
                                    res = add_byte(res, s_tdata);
                                end
                            end
                            MODE_OCTAL:
                            begin
                                if (is_oct)
                                begin
                                    value_next = oct_val;
                                    count_next = count_reg + 2'd1;
                                    if (count_reg == 2'd2)
                                    begin
                                        res        = add_byte(res, oct_val[7:0]);
                                        mode_next  = MODE_NORMAL;
                                        count_next = 2'd0;
                                        value_next = 9'd0;
                                    end
                                end
                                else
                                begin
                                    res        = add_byte(res, value_reg[7:0]);
                                    mode_next  = MODE_NORMAL;
                                    count_next = 2'd0;
                                    value_next = 9'd0;
                                    if (s_tdata == CHAR_BACKSLASH)
                                        mode_next = MODE_BACKSLASH;
                                    else
                                        res = add_byte(res, s_tdata);
                                end
                            end
                            MODE_HEX:
                            begin
                                if (hx.hit)
                                begin
                                    value_next = hex_val;
                                    count_next = count_reg + 2'd1;
                                    if (count_reg == 2'd1)
                                    begin
                                        res        = add_byte(res, hex_val[7:0]);
                                        mode_next  = MODE_NORMAL;
                                        count_next = 2'd0;
                                        value_next = 9'd0;
                                    end
                                end
                                else
                                begin
                                    res        = add_byte(res, value_reg[7:0]);
                                    mode_next  = MODE_NORMAL;
                                    count_next = 2'd0;
                                    value_next = 9'd0;
                                    if (s_tdata == CHAR_BACKSLASH)
                                        mode_next = MODE_BACKSLASH;
                                    else
                                        res = add_byte(res, s_tdata);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_END_ARG:
            begin
                if (!stopped_reg)
                begin
                    if (open_reg)
                    begin
                        if (mode_reg == MODE_BACKSLASH)
                            res = add_byte(res, CHAR_BACKSLASH);
                        else if (mode_reg != MODE_NORMAL)
                            res = add_byte(res, value_reg[7:0]);
                        mode_next  = MODE_NORMAL;
                        count_next = 2'd0;
                        value_next = 9'd0;
                    end
                    else
                    begin
                        if (!first_reg)
                            res = add_byte(res, CHAR_SPACE);
                        first_next = 1'b0;
                    end
                    open_next = 1'b0;
                end
            end
            OP_END_ALL:
            begin
                if (!stopped_reg)
                begin
                    if (open_reg)
                    begin
                        if (mode_reg == MODE_BACKSLASH)
                            res = add_byte(res, CHAR_BACKSLASH);
                        else if (mode_reg != MODE_NORMAL)
                            res = add_byte(res, value_reg[7:0]);
                    end
                    if (!suppress_reg)
                        res = add_byte(res, CHAR_NEWLINE);
                end
                mode_next    = MODE_NORMAL;
                count_next   = 2'd0;
                value_next   = 9'd0;
                first_next   = 1'b1;
                open_next    = 1'b0;
                stopped_next = 1'b0;
            end
            default: ;
        endcase
    end

    assign push_valid    = accept && (res.cnt != 2'd0);
    assign push_entry.two = res.cnt[1];
    assign push_entry.b0  = res.b0;
    assign push_entry.b1  = res.b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg   <= 1'b0;
            suppress_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INTERPRET_ESCAPES: interp_reg   <= cfg_data;
                REG_SUPPRESS_NEWLINE:  suppress_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            count_reg   <= 2'd0;
            value_reg   <= 9'd0;
            first_reg   <= 1'b1;
            open_reg    <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            value_reg   <= value_next;
            first_reg   <= first_next;
            open_reg    <= open_next;
            stopped_reg <= stopped_next;
        end
    end

    a_stop_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (mode_reg == MODE_NORMAL && count_reg == 2'd0))
        else $error("escape pending after stop");

    a_normal_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_NORMAL) |-> (count_reg == 2'd0 && value_reg == 9'd0))
        else $error("digit state left in normal mode");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> queue_ready)
        else $error("push into full queue");

endmodule

// ===== rtl/eesd_queue.sv =====
module eesd_queue #(
    parameter int DEPTH = eesd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  eesd_pkg::qentry_t push_entry,
    output logic              push_ready,
    output logic              pop_valid,
    output eesd_pkg::qentry_t pop_entry,
    input  logic              pop
);
    import eesd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

// ===== rtl/eesd_back.sv =====
module eesd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  eesd_pkg::qentry_t pop_entry,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tlast    // last_of_run
);
    import eesd_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       pending_reg;
    logic [7:0] hold_reg;
    logic       load;

    assign load     = !valid_reg || m_tready;
    assign pop      = load && !pending_reg && pop_valid;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (load)
        begin
            if (pending_reg)
            begin
                valid_reg   <= 1'b1;
                pending_reg <= 1'b0;
            end
            else
            begin
                valid_reg   <= pop_valid;
                pending_reg <= pop_valid && pop_entry.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pending_reg)
            begin
                data_reg <= hold_reg;
                last_reg <= 1'b1;
            end
            else
            begin
                data_reg <= pop_entry.b0;
                last_reg <= !pop_entry.two;
                hold_reg <= pop_entry.b1;
            end
        end
    end

    a_pending_shows_first: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (valid_reg && !last_reg))
        else $error("second byte pending without first on output");

    a_pending_then_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && m_tready) |=> (valid_reg && last_reg && !pending_reg))
        else $error("second byte not delivered after first");

endmodule

// ===== rtl/echo_escape_stream_decoder_core.sv =====
// echo-style byte stream decoder with optional backslash escape decoding
//
// s_* channel: one word per item, s_tuser carries the opcode (argument byte,
// end of argument, end of all) and s_tdata the argument byte.
// m_* channel: one output byte per word, m_tlast marks the final byte that an
// input item produced. items that produce nothing give no output word.
// cfg_* channel: register writes (index 0 interpret_escapes, index 1
// suppress_newline), always ready, to be written only while the block is idle.
//
// the front decoder takes one item per cycle while the queue has room and
// pushes its one or two bytes into a small queue; the back end drains the
// queue one byte per cycle while the receiver is ready. an accepted item is
// written into the queue and from there into the back end's output register.
// throughput is one input item per cycle as long as items average one output
// byte or less; two-byte items hold the back end for both bytes and fill the
// queue, and s_tready drops only when the queue is full. when the receiver
// stalls, the output word holds and the queue absorbs up to QUEUE_DEPTH items
// before s_tready goes low. reset clears the queue, the output register and all
// decoder state; both configuration registers return to 0.
module echo_escape_stream_decoder_core #(
    parameter int QUEUE_DEPTH = eesd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,    // opcode
    input  logic [7:0] s_tdata,    // data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic       m_tlast,    // last_of_run
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic       cfg_data
);
    import eesd_pkg::*;

    logic    push_valid;
    qentry_t push_entry;
    logic    push_ready;
    logic    pop_valid;
    qentry_t pop_entry;
    logic    pop;

    eesd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_ready (push_ready),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    eesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    eesd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import eesd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } echo_word_t;

    class echo_output_checker;
        echo_word_t expected_words[$];
        logic [7:0] item_bytes[$];
        bit         interpret;
        bit         suppress;
        logic [1:0] mode;
        logic [1:0] digits;
        logic [8:0] value;
        bit         first_arg;
        bit         arg_open;
        bit         stopped;
        int         mismatch_count;
        int         words_checked;
        int         items_noted;

        function new();
            interpret = 1'b0;
            suppress = 1'b0;
            clear_escape();
            first_arg = 1'b1;
            arg_open = 1'b0;
            stopped = 1'b0;
            mismatch_count = 0;
            words_checked = 0;
            items_noted = 0;
        endfunction

        function void write_reg(logic [0:0] index, logic value_bit);
            if (index == REG_INTERPRET_ESCAPES)
                interpret = value_bit;
            else
                suppress = value_bit;
        endfunction

        function void clear_escape();
            mode = MODE_NORMAL;
            digits = 2'd0;
            value = 9'd0;
        endfunction

        function void emit(logic [7:0] b);
            item_bytes.push_back(b);
        endfunction

        function void plain_byte(logic [7:0] b);
            if (b == CHAR_BACKSLASH)
                mode = MODE_BACKSLASH;
            else
                emit(b);
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return int'(b) - 48;
            if (b >= "a" && b <= "f")
                return int'(b) - 87;
            if (b >= "A" && b <= "F")
                return int'(b) - 55;
            return -1;
        endfunction

        function void escaped_letter(logic [7:0] b);
            mode = MODE_NORMAL;
            case (b)
                "a": emit(8'd7);
                "b": emit(8'd8);
                "c": stopped = 1'b1;
                "e": emit(CHAR_ESC);
                "f": emit(8'd12);
                "n": emit(CHAR_NEWLINE);
                "r": emit(8'd13);
                "t": emit(8'd9);
                "v": emit(8'd11);
                CHAR_BACKSLASH: emit(CHAR_BACKSLASH);
                "x":
                begin
                    mode = MODE_HEX;
                    digits = 2'd0;
                    value = 9'd0;
                end
                default:
                begin
                    if (b >= "0" && b <= "7")
                    begin
                        mode = MODE_OCTAL;
                        digits = 2'd1;
                        value = {6'd0, b[2:0]};
                    end
                    else
                    begin
                        emit(CHAR_BACKSLASH);
                        emit(b);
                    end
                end
            endcase
        endfunction

        function void escape_input(logic [7:0] b);
            int d;
            case (mode)
                MODE_NORMAL: plain_byte(b);
                MODE_BACKSLASH: escaped_letter(b);
                MODE_OCTAL:
                begin
                    if (b >= "0" && b <= "7")
                    begin
                        value = {value[5:0], b[2:0]};
                        digits = digits + 2'd1;
                        if (digits == 2'd3)
                        begin
                            emit(value[7:0]);
                            clear_escape();
                        end
                    end
                    else
                    begin
                        emit(value[7:0]);
                        clear_escape();
                        plain_byte(b);
                    end
                end
                default:
                begin
                    d = hex_digit(b);
                    if (d >= 0)
                    begin
                        value = {value[4:0], 4'(d)};
                        digits = digits + 2'd1;
                        if (digits == 2'd2)
                        begin
                            emit(value[7:0]);
                            clear_escape();
                        end
                    end
                    else
                    begin
                        emit(value[7:0]);
                        clear_escape();
                        plain_byte(b);
                    end
                end
            endcase
        endfunction

        function void flush_pending();
            if (mode == MODE_BACKSLASH)
                emit(CHAR_BACKSLASH);
            else if (mode == MODE_OCTAL || mode == MODE_HEX)
                emit(value[7:0]);
            clear_escape();
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] b);
            item_bytes.delete();
            items_noted++;
            case (op)
                OP_BYTE:
                begin
                    if (!stopped)
                    begin
                        if (!arg_open)
                        begin
                            if (!first_arg)
                                emit(CHAR_SPACE);
                            first_arg = 1'b0;
                            arg_open = 1'b1;
                        end
                        if (interpret)
                            escape_input(b);
                        else
                            emit(b);
                    end
                end
                OP_END_ARG:
                begin
                    if (!stopped)
                    begin
                        if (arg_open)
                            flush_pending();
                        else
                        begin
                            if (!first_arg)
                                emit(CHAR_SPACE);
                            first_arg = 1'b0;
                        end
                        arg_open = 1'b0;
                    end
                end
                OP_END_ALL:
                begin
                    if (!stopped)
                    begin
                        if (arg_open)
                            flush_pending();
                        if (!suppress)
                            emit(CHAR_NEWLINE);
                    end
                    clear_escape();
                    first_arg = 1'b1;
                    arg_open = 1'b0;
                    stopped = 1'b0;
                end
                default: ;
            endcase
            foreach (item_bytes[i])
                expected_words.push_back('{data: item_bytes[i],
                                           last: (i == item_bytes.size() - 1)});
        endfunction

        task report(string what);
            mismatch_count++;
            if (mismatch_count <= 20)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_word(logic [7:0] data, logic last);
            echo_word_t want;
            words_checked++;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected word %h last %b", data, last));
                return;
            end
            want = expected_words.pop_front();
            if (data !== want.data)
                report($sformatf("byte %h, wanted %h", data, want.data));
            if (last !== want.last)
                report($sformatf("last %b, wanted %b on byte %h", last, want.last, want.data));
        endtask
    endclass

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int LONG_HOLD = 120;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [1:0] s_tuser;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic       cfg_data;

    echo_output_checker predicted = new();

    int    send_max_gap = 0;
    int    recv_max_gap = 0;
    int    hold_request = 0;
    int    idle_cycles = 0;
    int    items_sent = 0;
    string named_letters = "abefnrtv\\";
    bit    interp_by_phase[PHASES] = '{1, 1, 0, 1, 0, 1, 1, 0};
    bit    supp_by_phase[PHASES] = '{0, 1, 0, 0, 1, 1, 0, 0};

    echo_escape_stream_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                predicted.check_word(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                predicted.note_item(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                predicted.write_reg(cfg_index, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no word moved for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // output side: random stalls per word, plus one long hold-off on request
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            gap = $urandom_range(0, recv_max_gap);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_mark(logic [1:0] op);
        send_item(op, 8'($urandom_range(0, 255)));
    endtask

    task automatic apply_settings(bit interp, bit supp);
        cfg_valid <= 1'b1;
        cfg_index <= REG_INTERPRET_ESCAPES;
        cfg_data <= interp;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= REG_SUPPRESS_NEWLINE;
        cfg_data <= supp;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (predicted.expected_words.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] octal_char();
        return 8'h30 + 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return 8'h30 + 8'(v);
        if (v < 16)
            return 8'h61 + 8'(v - 10);
        return 8'h41 + 8'(v - 16);
    endfunction

    task automatic send_random_chunk();
        int kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            b = 8'($urandom_range(0, 255));
            send_byte((b == CHAR_BACKSLASH) ? 8'h41 : b);
        end
        else if (kind < 35)
            send_byte(8'($urandom_range(0, 255)));
        else if (kind < 45)
        begin
            send_byte(CHAR_BACKSLASH);
            send_byte(named_letters[$urandom_range(0, 8)]);
        end
        else if (kind < 57)
        begin
            send_byte(CHAR_BACKSLASH);
            repeat ($urandom_range(1, 3)) send_byte(octal_char());
        end
        else if (kind < 68)
        begin
            send_byte(CHAR_BACKSLASH);
            send_byte("x");
            repeat ($urandom_range(0, 2)) send_byte(hex_char());
        end
        else if (kind < 75)
        begin
            send_byte(CHAR_BACKSLASH);
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 77)
        begin
            send_byte(CHAR_BACKSLASH);
            send_byte("c");
        end
        else if (kind < 89)
            send_mark(OP_END_ARG);
        else if (kind < 94)
            send_mark(OP_END_ALL);
        else if (kind < 96)
            send_mark(OP_UNUSED);
        else
        begin
            send_byte(CHAR_BACKSLASH);
            send_mark(($urandom_range(0, 1) == 0) ? OP_END_ARG : OP_END_ALL);
        end
    endtask

    initial
    begin
        int target;
        s_tvalid <= 1'b0;
        s_tuser <= OP_BYTE;
        s_tdata <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_INTERPRET_ESCAPES;
        cfg_data <= 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: escape mode with a selection of special cases
        apply_settings(1'b1, 1'b0);
        send_max_gap = 12;
        recv_max_gap = 12;
        send_mark(OP_UNUSED);
        send_mark(OP_END_ARG);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CHAR_BACKSLASH);
        send_byte("n");
        send_byte(CHAR_BACKSLASH);
        send_byte("7");
        send_byte("7");
        send_byte("7");
        send_byte(CHAR_BACKSLASH);
        send_byte("x");
        send_byte("g");
        send_byte(CHAR_BACKSLASH);
        send_byte("1");
        send_byte("z");
        send_byte(CHAR_BACKSLASH);
        send_byte("q");
        send_byte(CHAR_BACKSLASH);
        send_mark(OP_END_ARG);
        send_mark(OP_END_ARG);
        send_byte(CHAR_BACKSLASH);
        send_byte("c");
        send_byte("a");
        send_mark(OP_END_ALL);
        send_mark(OP_END_ALL);
        drain();

        target = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            apply_settings(interp_by_phase[p], supp_by_phase[p]);
            send_max_gap = (p % 3 == 1) ? 0 : 12;
            recv_max_gap = (p % 3 == 2) ? 0 : 12;
            if (p == 3)
            begin
                send_max_gap = 0;
                hold_request = LONG_HOLD;
            end
            target += ITEMS_PER_PHASE;
            while (items_sent < target)
                send_random_chunk();
            // leave an escape pending across the settings change
            send_byte(CHAR_BACKSLASH);
            send_byte(octal_char());
            drain();
        end

        if (predicted.expected_words.size() != 0)
            predicted.report($sformatf("%0d words never arrived",
                                       predicted.expected_words.size()));
        $display("accepted %0d input items, checked %0d output words over %0d settings",
                 predicted.items_noted, predicted.words_checked, PHASES + 1);
        $display("mismatches seen: %0d", predicted.mismatch_count);
        if (predicted.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
